// ===== hdl/pfba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfba_pkg
// Shared constants and types for the page-frame bitmap allocator.
// ----------------------------------------------------------------------------
package pfba_pkg;

    // frames managed and page geometry
    localparam int NUM_FRAMES = 65536;
    localparam int PAGE_SHIFT = 12;

    // bitmap organization: one bit per frame in 32-bit words
    localparam int WORD_BITS  = 32;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int NUM_WORDS  = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW    = $clog2(NUM_WORDS);
    localparam int SCAN_W     = WORD_AW + 1;
    localparam int FRAME_W    = WORD_AW + BIT_W;

    // field widths
    localparam int MODE_W     = 3;
    localparam int PHYS_W     = 48;
    localparam int PFRAME_W   = PHYS_W - PAGE_SHIFT;
    localparam int LIMIT_W    = 17;
    localparam int COUNT_W    = 17;
    localparam int ADDR_W     = 28;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 48;

    // limit clamp and reset value
    localparam int LIMIT_MAX  = (1 << LIMIT_W) - 1;
    localparam int EFF_MAX    = (NUM_FRAMES > LIMIT_MAX) ? LIMIT_MAX : NUM_FRAMES;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(EFF_MAX);
    localparam logic [LIMIT_W-1:0] LIMIT_CLAMP = LIMIT_W'(EFF_MAX);
    localparam logic [COUNT_W-1:0] COUNT_SAT   = {COUNT_W{1'b1}};

    // request modes
    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC     = 3'd0,
        MODE_FREE      = 3'd1,
        MODE_MARK_USED = 3'd2,
        MODE_MARK_FREE = 3'd3,
        MODE_TEST      = 3'd4
    } t_mode;

    // control states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MODIFY,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== hdl/page_frame_bitmap_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator
// First-fit page-frame allocator over a one-bit-per-frame usage bitmap held in
// a single synchronous memory (1 = used).
//
//   channel   dir  signals                      contents
//   s_axis    in   tvalid tready tdata tuser    request: phys_addr, mode
//   m_axis    out  tvalid tready tdata tuser    result: addr, used, count, status
//   cfg       in   i_cfg_wr_en i_cfg_wr_data    frame_limit
//
// After reset the bitmap is swept to all ones, one word a cycle over all 2048 words,
// with s_axis_tready low; cfg writes are taken throughout.
// Free, mark and test go from beat to beat through read, modify-write and result;
// an out-of-range frame or an unused mode goes straight to the result. Alloc reads
// bitmap words from the hint word up through the one read port, one word a cycle,
// checking each word once its registered read returns, then gives the result.
// A result waiting on m_axis holds the next request in the final step only.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // request beat
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [pfba_pkg::S_DATA_W-1:0]       s_axis_tdata,  // [47:0] phys_addr
    input  wire  [pfba_pkg::MODE_W-1:0]         s_axis_tuser,  // [2:0] mode
    // result beat
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // [27:0] alloc_addr, [28] frame_used, [45:29] allocated_pages, [47:46] zero
    output logic [pfba_pkg::M_DATA_W-1:0]       m_axis_tdata,
    output logic [0:0]                          m_axis_tuser,  // [0] status
    // configuration
    input  wire                                 i_cfg_wr_en,
    input  wire  [pfba_pkg::LIMIT_W-1:0]        i_cfg_wr_data
);

    localparam int WORD_AW  = pfba_pkg::WORD_AW;
    localparam int WORD_W   = pfba_pkg::WORD_BITS;
    localparam int BIT_W    = pfba_pkg::BIT_W;
    localparam int FRAME_W  = pfba_pkg::FRAME_W;
    localparam int SCAN_W   = pfba_pkg::SCAN_W;
    localparam int LIMIT_W  = pfba_pkg::LIMIT_W;
    localparam int COUNT_W  = pfba_pkg::COUNT_W;
    localparam int ADDR_W   = pfba_pkg::ADDR_W;
    localparam int PFRAME_W = pfba_pkg::PFRAME_W;
    localparam int PSHIFT   = pfba_pkg::PAGE_SHIFT;
    localparam int M_DATA_W_PAD = pfba_pkg::M_DATA_W - ADDR_W - 1 - COUNT_W;

    // control registers
    pfba_pkg::t_state       r_state,     n_state;
    logic [WORD_AW-1:0]     r_clr_addr,  n_clr_addr;
    logic                   r_out_valid, n_out_valid;
    logic [LIMIT_W-1:0]     r_hint,      n_hint;
    logic [COUNT_W-1:0]     r_count,     n_count;
    logic [LIMIT_W-1:0]     r_limit,     n_limit;
    logic                   r_chk_valid, n_chk_valid;

    // payload registers
    pfba_pkg::t_mode        r_mode,      n_mode;
    logic [FRAME_W-1:0]     r_frame,     n_frame;
    logic [SCAN_W-1:0]      r_rd_word,   n_rd_word;
    logic [WORD_AW-1:0]     r_chk_word,  n_chk_word;
    logic [ADDR_W-1:0]      r_res_addr,  n_res_addr;
    logic                   r_res_used,  n_res_used;
    logic                   r_res_stat,  n_res_stat;
    logic [ADDR_W-1:0]      r_out_addr,  n_out_addr;
    logic                   r_out_used,  n_out_used;
    logic                   r_out_stat,  n_out_stat;
    logic [COUNT_W-1:0]     r_out_pages, n_out_pages;

    // bitmap memory
    logic [WORD_W-1:0]      mem [pfba_pkg::NUM_WORDS];
    logic [WORD_W-1:0]      r_mem_q;
    logic                   mem_we;
    logic [WORD_AW-1:0]     mem_waddr;
    logic [WORD_W-1:0]      mem_wdata;
    logic                   mem_re;
    logic [WORD_AW-1:0]     mem_raddr;

    // derived values
    logic [LIMIT_W-1:0]     eff_lim;
    logic [SCAN_W-1:0]      word_end;
    logic [PFRAME_W-1:0]    in_frame;
    logic                   in_range;
    logic [WORD_W-1:0]      zero_bits;
    logic [WORD_W-1:0]      low_zero;
    logic [BIT_W-1:0]       zero_pos;
    logic [FRAME_W-1:0]     found_frame;
    logic [WORD_W-1:0]      bit_mask;
    logic                   s_beat;
    logic                   m_beat;

    assign s_beat = s_axis_tvalid && s_axis_tready;
    assign m_beat = r_out_valid && m_axis_tready;

    // effective limit and end of the scan in words
    assign eff_lim  = (r_limit > pfba_pkg::LIMIT_CLAMP) ? pfba_pkg::LIMIT_CLAMP : r_limit;
    assign word_end = SCAN_W'(({1'b0, eff_lim} + (LIMIT_W + 1)'(WORD_W - 1)) >> BIT_W);

    // request frame number and range check
    assign in_frame = s_axis_tdata[pfba_pkg::PHYS_W-1:PSHIFT];
    assign in_range = (in_frame[PFRAME_W-1:FRAME_W] == '0)
                   && ({1'b0, in_frame[FRAME_W-1:0]} < eff_lim);

    // lowest zero bit of the word just read
    assign zero_bits = ~r_mem_q;
    assign low_zero  = zero_bits & (~zero_bits + WORD_W'(1));
    always_comb begin
        zero_pos = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (low_zero[i]) begin
                zero_pos = zero_pos | BIT_W'(i);
            end
        end
    end
    assign found_frame = {r_chk_word, zero_pos};

    // bit select for single-frame updates
    assign bit_mask = WORD_W'(1) << r_frame[BIT_W-1:0];

    // next state, memory accesses and results
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid;
        n_hint      = r_hint;
        n_count     = r_count;
        n_limit     = r_limit;
        n_chk_valid = r_chk_valid;
        n_mode      = r_mode;
        n_frame     = r_frame;
        n_rd_word   = r_rd_word;
        n_chk_word  = r_chk_word;
        n_res_addr  = r_res_addr;
        n_res_used  = r_res_used;
        n_res_stat  = r_res_stat;
        n_out_addr  = r_out_addr;
        n_out_used  = r_out_used;
        n_out_stat  = r_out_stat;
        n_out_pages = r_out_pages;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        s_axis_tready = (r_state == pfba_pkg::ST_IDLE);

        if (i_cfg_wr_en) begin
            n_limit = i_cfg_wr_data;
        end

        if (m_beat) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            // sweep the bitmap to all used
            pfba_pkg::ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '1;
                n_clr_addr = r_clr_addr + WORD_AW'(1);
                if (r_clr_addr == WORD_AW'(pfba_pkg::NUM_WORDS - 1)) begin
                    n_state = pfba_pkg::ST_IDLE;
                end
            end

            // take a request, start the read that free, mark and test need
            pfba_pkg::ST_IDLE: begin
                if (s_beat) begin
                    n_mode      = pfba_pkg::t_mode'(s_axis_tuser);
                    n_frame     = in_frame[FRAME_W-1:0];
                    n_res_addr  = '0;
                    n_res_used  = 1'b0;
                    n_res_stat  = 1'b0;
                    n_chk_valid = 1'b0;
                    n_rd_word   = r_hint[LIMIT_W-1:BIT_W];
                    mem_raddr   = in_frame[FRAME_W-1:BIT_W];
                    case (pfba_pkg::t_mode'(s_axis_tuser))
                        pfba_pkg::MODE_ALLOC: begin
                            n_state = pfba_pkg::ST_SCAN;
                        end
                        pfba_pkg::MODE_FREE,
                        pfba_pkg::MODE_MARK_USED,
                        pfba_pkg::MODE_MARK_FREE: begin
                            if (s_axis_tuser == pfba_pkg::MODE_FREE && r_count != '0) begin
                                n_count = r_count - COUNT_W'(1);
                            end
                            mem_re  = in_range;
                            n_state = in_range ? pfba_pkg::ST_MODIFY : pfba_pkg::ST_DONE;
                        end
                        pfba_pkg::MODE_TEST: begin
                            mem_re     = in_range;
                            n_res_used = !in_range;
                            n_state    = in_range ? pfba_pkg::ST_MODIFY : pfba_pkg::ST_DONE;
                        end
                        default: begin
                            n_state = pfba_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            // walk words from the hint, checking the one read last cycle
            pfba_pkg::ST_SCAN: begin
                if (r_chk_valid && r_mem_q != '1) begin
                    if ({1'b0, found_frame} < eff_lim) begin
                        mem_we     = 1'b1;
                        mem_waddr  = r_chk_word;
                        mem_wdata  = r_mem_q | low_zero;
                        n_hint     = {1'b0, found_frame} + LIMIT_W'(1);
                        n_res_addr = ADDR_W'({found_frame, {PSHIFT{1'b0}}});
                        if (r_count != pfba_pkg::COUNT_SAT) begin
                            n_count = r_count + COUNT_W'(1);
                        end
                    end else begin
                        n_res_stat = 1'b1;
                    end
                    n_state = pfba_pkg::ST_DONE;
                end else if (r_rd_word < word_end) begin
                    mem_re      = 1'b1;
                    mem_raddr   = r_rd_word[WORD_AW-1:0];
                    n_chk_word  = r_rd_word[WORD_AW-1:0];
                    n_chk_valid = 1'b1;
                    n_rd_word   = r_rd_word + SCAN_W'(1);
                end else begin
                    n_res_stat = 1'b1;
                    n_state    = pfba_pkg::ST_DONE;
                end
            end

            // read-modify-write of one frame bit
            pfba_pkg::ST_MODIFY: begin
                mem_waddr = r_frame[FRAME_W-1:BIT_W];
                case (r_mode)
                    pfba_pkg::MODE_TEST: begin
                        n_res_used = r_mem_q[r_frame[BIT_W-1:0]];
                    end
                    pfba_pkg::MODE_MARK_USED: begin
                        mem_we    = 1'b1;
                        mem_wdata = r_mem_q | bit_mask;
                    end
                    pfba_pkg::MODE_FREE,
                    pfba_pkg::MODE_MARK_FREE: begin
                        mem_we    = 1'b1;
                        mem_wdata = r_mem_q & ~bit_mask;
                        if ({1'b0, r_frame} < r_hint) begin
                            n_hint = {1'b0, r_frame};
                        end
                    end
                    default: begin
                    end
                endcase
                n_state = pfba_pkg::ST_DONE;
            end

            // hand the result to the output register
            pfba_pkg::ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_addr  = r_res_addr;
                    n_out_used  = r_res_used;
                    n_out_stat  = r_res_stat;
                    n_out_pages = r_count;
                    n_state     = pfba_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = pfba_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfba_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_hint      <= '0;
            r_count     <= '0;
            r_limit     <= pfba_pkg::LIMIT_RESET;
            r_chk_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            r_hint      <= n_hint;
            r_count     <= n_count;
            r_limit     <= n_limit;
            r_chk_valid <= n_chk_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_frame     <= n_frame;
        r_rd_word   <= n_rd_word;
        r_chk_word  <= n_chk_word;
        r_res_addr  <= n_res_addr;
        r_res_used  <= n_res_used;
        r_res_stat  <= n_res_stat;
        r_out_addr  <= n_out_addr;
        r_out_used  <= n_out_used;
        r_out_stat  <= n_out_stat;
        r_out_pages <= n_out_pages;
    end

    // bitmap memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= mem[mem_raddr];
        end
    end

    // result beat
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_DATA_W_PAD){1'b0}}, r_out_pages, r_out_used, r_out_addr};
    assign m_axis_tuser  = r_out_stat;

endmodule
`default_nettype wire

// ===== tb/sv/tb_page_frame_bitmap_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_page_frame_bitmap_allocator
// Self-checking bench for the first-fit page-frame allocator. A predictor
// keeps its own usage bitmap, search hint, page count and frame limit and
// works out the result of every accepted request beat. Result beats are
// checked field by field in order. Directed requests cover the extremes and
// corner cases; random phases then sweep the frame limit with mostly
// well-formed alloc/free traffic, random idling on both sides and one long
// output stall that backs the block up into its request port.
// ----------------------------------------------------------------------------
module tb_page_frame_bitmap_allocator;
    import pfba_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 5;
    localparam int DRAIN_CYCLES   = 16;
    localparam int TIMEOUT_TIME   = 40_000_000;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int WINDOW_FRAMES  = 256;
    localparam int SLOW_LIMIT     = 2048;
    localparam int MAX_REPORTS    = 50;
    localparam int MODE_CODES     = 1 << MODE_W;
    localparam int PAGE_MASK      = (1 << PAGE_SHIFT) - 1;
    localparam logic [PHYS_W-1:0] PHYS_TOP = {PHYS_W{1'b1}};

    // expected contents of one result beat
    typedef struct packed {
        logic [ADDR_W-1:0]  alloc_addr;
        logic               frame_used;
        logic               status;
        logic [COUNT_W-1:0] pages;
    } page_result_t;

    // block ports
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [MODE_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [LIMIT_W-1:0]    i_cfg_wr_data = '0;

    // predictor state
    logic [WORD_BITS-1:0]  usage_words [NUM_WORDS];
    int                    hint_frame;
    logic [COUNT_W-1:0]    page_total;
    logic [LIMIT_W-1:0]    limit_reg;

    page_result_t          pending_results [$];
    int                    mismatch_count = 0;
    bit                    steady         = 1'b0;
    int                    hold_off_asked = 0;

    page_frame_bitmap_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    function automatic int eff_limit();
        return (int'(limit_reg) > NUM_FRAMES) ? NUM_FRAMES : int'(limit_reg);
    endfunction

    // free and mark free: clear an in-range frame and pull the hint down
    function automatic void clear_usage_bit(input logic [PFRAME_W-1:0] frame);
        int f;
        if (frame >= PFRAME_W'(eff_limit()))
            return;
        f = int'(frame);
        usage_words[f / WORD_BITS][f % WORD_BITS] = 1'b0;
        if (f < hint_frame)
            hint_frame = f;
    endfunction

    // lowest free frame from the hint word up to the limit
    function automatic bit find_lowest_free(output int found);
        int lim, w, wend, b, f;
        lim  = eff_limit();
        w    = hint_frame / WORD_BITS;
        wend = (lim + WORD_BITS - 1) / WORD_BITS;
        found = 0;
        while (w < wend && w < NUM_WORDS) begin
            if (usage_words[w] != '1) begin
                for (b = 0; b < WORD_BITS; b++) begin
                    f = w * WORD_BITS + b;
                    if (f >= lim)
                        return 1'b0;
                    if (!usage_words[w][b]) begin
                        found = f;
                        return 1'b1;
                    end
                end
            end
            w++;
        end
        return 1'b0;
    endfunction

    function automatic void compute_page_result(input logic [MODE_W-1:0] mode,
                                                input logic [PHYS_W-1:0] phys,
                                                output page_result_t res);
        logic [PFRAME_W-1:0] frame;
        bit                  in_range;
        int                  f;
        frame    = phys[PHYS_W-1:PAGE_SHIFT];
        in_range = frame < PFRAME_W'(eff_limit());
        res      = '0;
        case (mode)
            MODE_ALLOC: begin
                if (find_lowest_free(f)) begin
                    usage_words[f / WORD_BITS][f % WORD_BITS] = 1'b1;
                    hint_frame = f + 1;
                    if (page_total != COUNT_SAT)
                        page_total++;
                    res.alloc_addr = ADDR_W'(longint'(f) << PAGE_SHIFT);
                end else begin
                    res.status = 1'b1;
                end
            end
            MODE_FREE: begin
                clear_usage_bit(frame);
                if (page_total != '0)
                    page_total--;
            end
            MODE_MARK_USED: begin
                if (in_range) begin
                    f = int'(frame);
                    usage_words[f / WORD_BITS][f % WORD_BITS] = 1'b1;
                end
            end
            MODE_MARK_FREE: clear_usage_bit(frame);
            MODE_TEST: begin
                if (!in_range) begin
                    res.frame_used = 1'b1;
                end else begin
                    f = int'(frame);
                    res.frame_used = usage_words[f / WORD_BITS][f % WORD_BITS];
                end
            end
            default: ;
        endcase
        res.pages = page_total;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // idle length: mostly none or short, a few long
    function automatic int pick_idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return MODE_ALLOC;
        if (r < 58)
            return MODE_FREE;
        if (r < 68)
            return MODE_MARK_USED;
        if (r < 80)
            return MODE_MARK_FREE;
        if (r < 96)
            return MODE_TEST;
        return MODE_W'($urandom_range(MODE_TEST + 1, MODE_CODES - 1));
    endfunction

    function automatic logic [PHYS_W-1:0] frame_phys(input longint frame);
        return PHYS_W'(frame << PAGE_SHIFT);
    endfunction

    // address: mostly inside the working window, some at the limit edge,
    // some at the top of the bitmap, a few fully random
    function automatic logic [PHYS_W-1:0] pick_phys(input bit window_only);
        int unsigned r;
        int          win;
        longint      frame;
        win = (eff_limit() < WINDOW_FRAMES) ? eff_limit() : WINDOW_FRAMES;
        if (win == 0)
            win = 4;
        r = window_only ? 0 : $urandom_range(0, 99);
        if (r < 80)
            frame = $urandom_range(0, win - 1);
        else if (r < 88)
            frame = eff_limit() - 2 + $urandom_range(0, 3);
        else if (r < 95)
            frame = NUM_FRAMES - 4 + $urandom_range(0, 7);
        else
            return PHYS_W'({$urandom(), $urandom()});
        if (frame < 0)
            frame = 0;
        return frame_phys(frame) | PHYS_W'($urandom_range(0, PAGE_MASK));
    endfunction

    // one request beat, predicted once accepted
    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic [PHYS_W-1:0] phys);
        int           gap;
        page_result_t want;
        gap = steady ? 0 : pick_idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= phys;
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        compute_page_result(mode, phys, want);
        pending_results.push_back(want);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // limit writes only with the block idle
    task automatic write_frame_limit(input logic [LIMIT_W-1:0] value);
        wait_for_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        limit_reg = value;
    endtask

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        if (mismatch_count < MAX_REPORTS)
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    task automatic check_result();
        page_result_t want;
        if (pending_results.size() == 0) begin
            report_mismatch("unexpected result beat", m_axis_tdata, 0);
            return;
        end
        want = pending_results.pop_front();
        if (m_axis_tdata[ADDR_W-1:0] !== want.alloc_addr)
            report_mismatch("alloc_addr", m_axis_tdata[ADDR_W-1:0], want.alloc_addr);
        if (m_axis_tdata[ADDR_W] !== want.frame_used)
            report_mismatch("frame_used", m_axis_tdata[ADDR_W], want.frame_used);
        if (m_axis_tdata[ADDR_W+1 +: COUNT_W] !== want.pages)
            report_mismatch("allocated_pages", m_axis_tdata[ADDR_W+1 +: COUNT_W],
                            want.pages);
        if (m_axis_tuser[0] !== want.status)
            report_mismatch("status", m_axis_tuser[0], want.status);
    endtask

    // result side: check beats, drive ready with random stalls and hold-offs
    initial begin : result_monitor
        int ready_hold;
        int hold_off_left;
        int hold_off_seen;
        int stall;
        ready_hold    = 0;
        hold_off_left = 0;
        hold_off_seen = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
                check_result();
            if (hold_off_asked != hold_off_seen) begin
                hold_off_seen = hold_off_asked;
                hold_off_left = HOLD_OFF_LEN;
            end
            if (hold_off_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_off_left--;
            end else if (steady) begin
                m_axis_tready <= 1'b1;
            end else if (ready_hold > 0) begin
                ready_hold--;
            end else begin
                stall = pick_idle_len();
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    ready_hold = stall - 1;
                end else begin
                    m_axis_tready <= 1'b1;
                    ready_hold = $urandom_range(0, 7);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // every mode, frame zero, exhaustion, range edges, count floor, limit extremes
    task automatic test_modes_and_extremes();
        send_request(MODE_TEST, frame_phys(0));
        send_request(MODE_FREE, frame_phys(0));
        send_request(MODE_TEST, frame_phys(0) | PAGE_MASK);
        send_request(MODE_ALLOC, PHYS_TOP);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_MARK_FREE, frame_phys(NUM_FRAMES - 1) | PAGE_MASK);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_TEST, PHYS_TOP);
        send_request(MODE_FREE, PHYS_TOP);
        send_request(MODE_MARK_FREE, frame_phys(NUM_FRAMES));
        send_request(MODE_MARK_USED, frame_phys(NUM_FRAMES));
        send_request(MODE_TEST, frame_phys(NUM_FRAMES));
        for (int m = MODE_TEST + 1; m < MODE_CODES; m++)
            send_request(MODE_W'(m), pick_phys(1'b0));
        send_request(MODE_MARK_FREE, frame_phys(5));
        send_request(MODE_MARK_USED, frame_phys(5));
        send_request(MODE_TEST, frame_phys(5));
        send_request(MODE_FREE, frame_phys(0));
        send_request(MODE_FREE, frame_phys(0));
        // no frames at all
        write_frame_limit('0);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_TEST, frame_phys(0));
        // a single frame
        write_frame_limit(LIMIT_W'(1));
        send_request(MODE_ALLOC, '0);
        send_request(MODE_ALLOC, '0);
        // limit above the bitmap acts as the bitmap size
        write_frame_limit(LIMIT_W'(LIMIT_MAX));
        send_request(MODE_TEST, frame_phys(NUM_FRAMES - 1));
        send_request(MODE_MARK_FREE, frame_phys(NUM_FRAMES - 1));
        send_request(MODE_TEST, frame_phys(NUM_FRAMES - 1));
    endtask

    // free a few frames in the window, then mixed traffic
    task automatic run_limit_phase(input int limit, input int items);
        write_frame_limit(LIMIT_W'(limit));
        repeat (12) send_request(MODE_MARK_FREE, pick_phys(1'b1));
        repeat (items) send_request(pick_mode(), pick_phys(1'b0));
    endtask

    task automatic test_limit_sweep();
        int limits [8];
        limits = '{NUM_FRAMES, $urandom_range(1, 64), WORD_BITS, WORD_BITS + 1,
                   $urandom_range(65, SLOW_LIMIT), LIMIT_MAX,
                   $urandom_range(1, WORD_BITS - 1),
                   $urandom_range(SLOW_LIMIT + 1, NUM_FRAMES - 1)};
        foreach (limits[i])
            run_limit_phase(limits[i], (limits[i] > SLOW_LIMIT) ? 40 : 90);
    endtask

    // back-to-back beats with the result side always ready
    task automatic test_steady_stream();
        wait_for_results();
        steady = 1'b1;
        run_limit_phase($urandom_range(40, 200), 40);
        wait_for_results();
        steady = 1'b0;
    endtask

    // long result stall while requests keep coming
    task automatic test_output_stall();
        write_frame_limit(LIMIT_W'(64));
        steady = 1'b1;
        hold_off_asked++;
        repeat (40) send_request(pick_mode(), pick_phys(1'b0));
        wait_for_results();
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial begin : stimulus
        foreach (usage_words[i])
            usage_words[i] = '1;
        hint_frame = 0;
        page_total = '0;
        limit_reg  = LIMIT_RESET;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_modes_and_extremes();
        test_limit_sweep();
        test_steady_stream();
        test_output_stall();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_TIME);
        $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
hdl/pfba_pkg.sv
hdl/page_frame_bitmap_allocator.sv
tb/sv/tb_page_frame_bitmap_allocator.sv
